FILE: rtl/core/rcss_pkg.sv
`timescale 1ns / 1ps

package rcss_pkg;

  // Size of the signature table; the entry index and slot fields are built for this size.
  localparam int SIG_ENTRIES = 16;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_DATA    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_WINDOW_WORDS    = 2'd0,
    CFG_SIGNATURE_COUNT = 2'd1,
    CFG_FILTER_ENABLE   = 2'd2,
    CFG_NONE            = 2'd3
  } cfg_index_e;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_MATCH  = 1'b1;

  // Opcode class patterns and the masks that keep only the non PC-relative bits.
  localparam logic [31:0] SEL_ADR_M   = 32'h3f000000;
  localparam logic [31:0] SEL_ADR_V   = 32'h1c000000;
  localparam logic [31:0] SEL_LDL_M   = 32'hbf000000;
  localparam logic [31:0] SEL_LDL_V   = 32'h18000000;
  localparam logic [31:0] SEL_LDSW_M  = 32'hff000000;
  localparam logic [31:0] SEL_LDSW_V  = 32'h98000000;
  localparam logic [31:0] SEL_ADRP_M  = 32'h8f000000;
  localparam logic [31:0] SEL_ADR0_V  = 32'h00000000;
  localparam logic [31:0] SEL_ADRP1_V = 32'h80000000;
  localparam logic [31:0] SEL_BR_M    = 32'hec000000;
  localparam logic [31:0] SEL_B_V     = 32'h04000000;
  localparam logic [31:0] SEL_BL_V    = 32'h84000000;
  localparam logic [31:0] SEL_ADD_M   = 32'h61000000;
  localparam logic [31:0] SEL_ADD_V   = 32'h01000000;
  localparam logic [31:0] SEL_LDQ_M   = 32'hffc00000;
  localparam logic [31:0] SEL_LDQ_V   = 32'h3dc00000;
  localparam logic [31:0] SEL_LDX_M   = 32'h9fc00000;
  localparam logic [31:0] SEL_LDX_V   = 32'h99400000;
  localparam logic [31:0] SEL_LDV_M   = 32'h1f400000;
  localparam logic [31:0] SEL_LDV_V   = 32'h1d400000;
  localparam logic [31:0] SEL_ADDI_M  = 32'h6f000000;
  localparam logic [31:0] SEL_ADDI_V  = 32'h01000000;

  localparam logic [31:0] KEEP_RD     = 32'hff00001f;
  localparam logic [31:0] KEEP_ADRP   = 32'h9f00001f;
  localparam logic [31:0] KEEP_OPC    = 32'hfc000000;
  localparam logic [31:0] KEEP_ADD    = 32'hff0003ff;
  localparam logic [31:0] KEEP_LDST   = 32'hffc00000;
  localparam logic [31:0] KEEP_ADDI   = 32'hffc003ff;

endpackage

FILE: rtl/core/rcss_pcrel_filter.sv
`timescale 1ns / 1ps

module rcss_pcrel_filter (
  input  logic [31:0] word_i,
  input  logic        enable_i,
  output logic [31:0] word_o
);
  import rcss_pkg::*;

  logic [31:0] masked;

  always_comb begin
    priority if ((word_i & SEL_ADR_M) == SEL_ADR_V) begin
      masked = word_i & KEEP_RD;
    end else if ((word_i & SEL_LDL_M) == SEL_LDL_V) begin
      masked = word_i & KEEP_RD;
    end else if ((word_i & SEL_LDSW_M) == SEL_LDSW_V) begin
      masked = word_i & KEEP_RD;
    end else if ((word_i & SEL_ADRP_M) == SEL_ADR0_V) begin
      masked = word_i & KEEP_ADRP;
    end else if ((word_i & SEL_BR_M) == SEL_B_V) begin
      masked = word_i & KEEP_OPC;
    end else if ((word_i & SEL_BR_M) == SEL_BL_V) begin
      masked = word_i & KEEP_OPC;
    end else if ((word_i & SEL_ADD_M) == SEL_ADD_V) begin
      masked = word_i & KEEP_ADD;
    end else if ((word_i & SEL_ADRP_M) == SEL_ADRP1_V) begin
      masked = word_i & KEEP_ADRP;
    end else if ((word_i & SEL_LDQ_M) == SEL_LDQ_V) begin
      masked = word_i & KEEP_LDST;
    end else if ((word_i & SEL_LDX_M) == SEL_LDX_V) begin
      masked = word_i & KEEP_LDST;
    end else if ((word_i & SEL_LDV_M) == SEL_LDV_V) begin
      masked = word_i & KEEP_LDST;
    end else if ((word_i & SEL_ADDI_M) == SEL_ADDI_V) begin
      masked = word_i & KEEP_ADDI;
    end else begin
      masked = word_i;
    end
  end

  assign word_o = enable_i ? masked : word_i;

endmodule

FILE: rtl/core/rcss_window_ram.sv
`timescale 1ns / 1ps

module rcss_window_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rolling_checksum_signature_search_top.sv
`timescale 1ns / 1ps

// Rolling checksum signature search. A data transaction passes the optional AArch64
// PC-relative mask, updates the rolling sums over a window held in a single-port-read
// ring RAM, then walks the signature table with one comparator, one entry per cycle
// while the output is not stalled; signature_count entries are compared, capped at
// SIG_ENTRIES. After reset and after a restart transaction the ring RAM is cleared one
// entry a cycle, and no input is accepted during the clear; configuration writes are
// taken at any time.
module rolling_checksum_signature_search_top #(
  parameter int WINDOW_MAX  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] sig_a_i,
  input  logic [31:0] sig_b_i,
  input  logic [31:0] data_word_i,
  input  logic        report_sums_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  match_entry_o,
  output logic [31:0] window_offset_o,
  output logic [31:0] sum_a_o,
  output logic [31:0] sum_b_o,
  output logic        last_o
);
  import rcss_pkg::*;

  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NW  = $clog2(WINDOW_MAX + 1);
  localparam int TIW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ROLL_A, S_ROLL_B, S_CMP, S_FLUSH, S_FIN
  } state_e;

  state_e      state_q;
  logic [AW-1:0] clr_q, wp_q, pos_q;
  logic [31:0] a_q, b_q, ws_q, w_q, prod_q;
  logic        rep_q;
  logic [4:0]  k_q;
  logic        pend_v_q, pend_kind_q;
  logic [3:0]  pend_entry_q;
  logic [10:0] win_q;
  logic [4:0]  cnt_cfg_q;
  logic        filt_q;
  logic [31:0] tab_a_q [SIG_ENTRIES];
  logic [31:0] tab_b_q [SIG_ENTRIES];

  logic        out_valid_q, out_kind_q, out_last_q;
  logic [3:0]  out_entry_q;
  logic [31:0] out_off_q, out_a_q, out_b_q;

  logic [NW-1:0] nwin;
  logic [AW-1:0] pos, pos_next;
  logic [4:0]    cnt;
  logic [TIW-1:0] tidx;
  logic [31:0]   filt_word, rdata, offset, ram_wdata;
  logic [AW-1:0] ram_waddr;
  logic          ram_we, hit, out_free;

  rcss_pcrel_filter u_filter (
    .word_i   (data_word_i),
    .enable_i (filt_q),
    .word_o   (filt_word)
  );

  rcss_window_ram #(.DEPTH(WINDOW_MAX), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos),
    .rdata_o (rdata)
  );

  always_comb begin
    if (win_q == 11'd0) begin
      nwin = NW'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      nwin = NW'(WINDOW_MAX);
    end else begin
      nwin = NW'(win_q);
    end
  end

  assign pos      = (32'(wp_q) >= 32'(nwin)) ? '0 : wp_q;
  assign pos_next = ((32'(pos_q) + 32'd1) >= 32'(nwin)) ? '0 : AW'(32'(pos_q) + 32'd1);
  assign cnt      = (32'(cnt_cfg_q) > 32'(SIG_ENTRIES)) ? 5'(SIG_ENTRIES) : cnt_cfg_q;
  assign tidx     = TIW'(k_q);
  assign hit      = (tab_a_q[tidx] == a_q) && (tab_b_q[tidx] == b_q);
  assign offset   = (ws_q - 32'(nwin)) << 2;
  assign out_free = !out_valid_q || out_ready_i;

  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_ROLL_A);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : pos_q;
  assign ram_wdata = (state_q == S_CLEAR) ? 32'd0 : w_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // The table has no reset: entries are only meaningful once loaded.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && req_type_i == REQ_LOAD &&
        32'(entry_index_i) < 32'(SIG_ENTRIES)) begin
      tab_a_q[TIW'(entry_index_i)] <= sig_a_i;
      tab_b_q[TIW'(entry_index_i)] <= sig_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      ws_q        <= '0;
      k_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= 11'd1;
      cnt_cfg_q   <= 5'd0;
      filt_q      <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_WORDS:    win_q     <= cfg_data_i;
          CFG_SIGNATURE_COUNT: cnt_cfg_q <= cfg_data_i[4:0];
          CFG_FILTER_ENABLE:   filt_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == 32'(WINDOW_MAX - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (req_type_i)
              REQ_DATA: begin
                w_q     <= filt_word;
                rep_q   <= report_sums_i;
                pos_q   <= pos;
                state_q <= S_ROLL_A;
              end
              REQ_RESTART: begin
                wp_q    <= '0;
                a_q     <= '0;
                b_q     <= '0;
                ws_q    <= '0;
                state_q <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_ROLL_A: begin
          a_q     <= a_q - rdata + w_q;
          prod_q  <= 32'(nwin * rdata);
          state_q <= S_ROLL_B;
        end
        S_ROLL_B: begin
          b_q     <= b_q - prod_q + a_q;
          wp_q    <= pos_next;
          ws_q    <= ws_q + 32'd1;
          k_q     <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          // A hit is held back one step so that the final result can carry last.
          if (k_q >= cnt) begin
            state_q <= S_FLUSH;
          end else if (!hit) begin
            k_q <= k_q + 1'b1;
          end else if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= pend_kind_q;
              out_entry_q <= pend_entry_q;
              out_off_q   <= offset;
              out_a_q     <= a_q;
              out_b_q     <= b_q;
              out_last_q  <= 1'b0;
            end
            pend_v_q     <= 1'b1;
            pend_kind_q  <= KIND_MATCH;
            pend_entry_q <= 4'(k_q);
            k_q          <= k_q + 1'b1;
          end
        end
        S_FLUSH: begin
          if (!rep_q) begin
            state_q <= S_FIN;
          end else if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= pend_kind_q;
              out_entry_q <= pend_entry_q;
              out_off_q   <= offset;
              out_a_q     <= a_q;
              out_b_q     <= b_q;
              out_last_q  <= 1'b0;
            end
            pend_v_q     <= 1'b1;
            pend_kind_q  <= KIND_REPORT;
            pend_entry_q <= 4'd0;
            state_q      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!pend_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= pend_kind_q;
            out_entry_q <= pend_entry_q;
            out_off_q   <= offset;
            out_a_q     <= a_q;
            out_b_q     <= b_q;
            out_last_q  <= 1'b1;
            pend_v_q    <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign match_entry_o   = out_entry_q;
  assign window_offset_o = out_off_q;
  assign sum_a_o         = out_a_q;
  assign sum_b_o         = out_b_q;
  assign last_o          = out_last_q;

  a_roll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROLL_A |=> state_q == S_ROLL_B)
    else $error("rolling update did not proceed to the second sum");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q)
    else $error("held result left behind when returning to idle");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o)
    else $error("input accepted during window clear");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == REQ_RESTART) |=>
      (state_q == S_CLEAR && a_q == 32'd0 && b_q == 32'd0 && ws_q == 32'd0))
    else $error("restart did not clear the rolling state");

endmodule
